### src/ispm_pkg.sv
`default_nettype none

package ispm_pkg;

  localparam int PATTERN_DEPTH_DEF  = 8;
  localparam int MAX_INSN_BYTES_DEF = 16;

  localparam int SLOT_W    = 3;
  localparam int COUNT_W   = 5;
  localparam int HALF_W    = 64;
  localparam int MASK_W    = 16;
  localparam int PLEN_W    = 4;
  localparam int SUM_W     = 8;

  // tdata of the slave side: slot, byte_count, bytes_low, bytes_high,
  // wildcard_mask, any_instruction, zero fill to whole bytes
  localparam int IN_SLOT_LSB  = 0;
  localparam int IN_COUNT_LSB = IN_SLOT_LSB + SLOT_W;
  localparam int IN_LOW_LSB   = IN_COUNT_LSB + COUNT_W;
  localparam int IN_HIGH_LSB  = IN_LOW_LSB + HALF_W;
  localparam int IN_MASK_LSB  = IN_HIGH_LSB + HALF_W;
  localparam int IN_ANY_LSB   = IN_MASK_LSB + MASK_W;
  localparam int IN_USED_W    = IN_ANY_LSB + 1;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_DATA_W   = SUM_W;

  typedef enum logic {
    ACT_INSN    = 1'b0,
    ACT_PATTERN = 1'b1
  } action_e;

endpackage

`default_nettype wire

### src/instruction_sequence_pattern_matcher.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: item fields, tuser: action
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: matched_bytes, tuser: matched
// cfg       in   cfg_valid_i / cfg_ready_o      cfg_data_i: pattern_length
//
// One word per cycle while m_axis_tready is high; input and result registers lie in series.
// The rate is set by the single compare stage between the input and result registers.
// Reset empties both stages and the instruction window; pattern slots hold until written.
// A stalled result holds in its register while the input register still takes a word.
`default_nettype none

module instruction_sequence_pattern_matcher
  import ispm_pkg::*;
#(
  parameter int PATTERN_DEPTH  = PATTERN_DEPTH_DEF,
  parameter int MAX_INSN_BYTES = MAX_INSN_BYTES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // slot, byte_count, bytes_low, bytes_high, wildcard_mask, any_instruction
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  wire logic                  s_axis_tuser,

  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // matched_bytes
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // matched
  output logic                       m_axis_tuser,

  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [PLEN_W-1:0]     cfg_data_i
);

  localparam int BYTES_W = MAX_INSN_BYTES * 8;
  localparam int CNT_W   = $clog2(PATTERN_DEPTH + 1);

  logic [PLEN_W-1:0]      plen_q;

  logic                   in_vld_q;
  action_e                in_act_q;
  logic [SLOT_W-1:0]      in_slot_q;
  logic [COUNT_W-1:0]     in_size_q;
  logic [BYTES_W-1:0]     in_bytes_q;
  logic [MAX_INSN_BYTES-1:0] in_mask_q;
  logic                   in_any_q;

  logic                   out_vld_q;
  logic                   out_matched_q;
  logic [SUM_W-1:0]       out_bytes_q;

  logic [BYTES_W-1:0]     win_bytes_q [PATTERN_DEPTH];
  logic [COUNT_W-1:0]     win_size_q  [PATTERN_DEPTH];
  logic [CNT_W-1:0]       fill_q;

  logic [BYTES_W-1:0]     pat_bytes_q [PATTERN_DEPTH];
  logic [MAX_INSN_BYTES-1:0] pat_mask_q [PATTERN_DEPTH];
  logic [COUNT_W-1:0]     pat_size_q  [PATTERN_DEPTH];
  logic                   pat_any_q   [PATTERN_DEPTH];

  logic [BYTES_W-1:0]     win_bytes_d [PATTERN_DEPTH];
  logic [COUNT_W-1:0]     win_size_d  [PATTERN_DEPTH];
  logic [CNT_W-1:0]       fill_d;
  logic [CNT_W-1:0]       len;
  logic [PATTERN_DEPTH-1:0] slot_ok;
  logic [SUM_W-1:0]       total;
  logic                   matched_d;

  logic                   s_accept;
  logic                   advance;
  logic [COUNT_W-1:0]     s_count;
  logic [COUNT_W-1:0]     s_size;
  logic [2*HALF_W-1:0]    s_bytes;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign s_count = s_axis_tdata[IN_COUNT_LSB +: COUNT_W];
  assign s_size  = (32'(s_count) > MAX_INSN_BYTES) ? COUNT_W'(MAX_INSN_BYTES) : s_count;
  assign s_bytes = {s_axis_tdata[IN_HIGH_LSB +: HALF_W], s_axis_tdata[IN_LOW_LSB +: HALF_W]};

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_bytes_q;
  assign m_axis_tuser  = out_matched_q;

  assign len = (32'(plen_q) > PATTERN_DEPTH) ? CNT_W'(PATTERN_DEPTH) : CNT_W'(plen_q);
  assign fill_d = (32'(fill_q) < PATTERN_DEPTH) ? fill_q + CNT_W'(1) : fill_q;

  always_comb begin
    win_bytes_d[0] = in_bytes_q;
    win_size_d[0]  = in_size_q;
    for (int k = 1; k < PATTERN_DEPTH; k++) begin
      win_bytes_d[k] = win_bytes_q[k-1];
      win_size_d[k]  = win_size_q[k-1];
    end
  end

  always_comb begin
    logic [BYTES_W-1:0] sel_bytes;
    logic [COUNT_W-1:0] sel_size;
    logic               bytes_eq;
    int                 idx;
    for (int s = 0; s < PATTERN_DEPTH; s++) begin
      idx       = int'(len) - 1 - s;
      sel_bytes = '0;
      sel_size  = '0;
      for (int k = 0; k < PATTERN_DEPTH; k++) begin
        if (idx == k) begin
          sel_bytes = win_bytes_d[k];
          sel_size  = win_size_d[k];
        end
      end
      bytes_eq = 1'b1;
      for (int b = 0; b < MAX_INSN_BYTES; b++) begin
        if (32'(pat_size_q[s]) > b && !pat_mask_q[s][b] &&
            pat_bytes_q[s][8*b +: 8] != sel_bytes[8*b +: 8]) begin
          bytes_eq = 1'b0;
        end
      end
      slot_ok[s] = (idx < 0) || pat_any_q[s] || (pat_size_q[s] == sel_size && bytes_eq);
    end
  end

  always_comb begin
    total = '0;
    for (int k = 0; k < PATTERN_DEPTH; k++) begin
      if (k < int'(len)) begin
        total = total + SUM_W'(win_size_d[k]);
      end
    end
  end

  assign matched_d = (len != '0) && (fill_d >= len) && (&slot_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q    <= '0;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      fill_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        plen_q <= cfg_data_i;
      end
      if (s_accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (advance && in_act_q == ACT_INSN) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_act_q   <= action_e'(s_axis_tuser);
      in_slot_q  <= s_axis_tdata[IN_SLOT_LSB +: SLOT_W];
      in_size_q  <= s_size;
      in_bytes_q <= s_bytes[BYTES_W-1:0];
      in_mask_q  <= s_axis_tdata[IN_MASK_LSB +: MAX_INSN_BYTES];
      in_any_q   <= s_axis_tdata[IN_ANY_LSB];
    end
    if (advance) begin
      if (in_act_q == ACT_INSN) begin
        out_matched_q <= matched_d;
        out_bytes_q   <= matched_d ? total : '0;
        for (int k = 0; k < PATTERN_DEPTH; k++) begin
          win_bytes_q[k] <= win_bytes_d[k];
          win_size_q[k]  <= win_size_d[k];
        end
      end else begin
        out_matched_q <= 1'b0;
        out_bytes_q   <= '0;
        for (int s = 0; s < PATTERN_DEPTH; s++) begin
          if (32'(in_slot_q) == s) begin
            pat_bytes_q[s] <= in_bytes_q;
            pat_mask_q[s]  <= in_mask_q;
            pat_size_q[s]  <= in_size_q;
            pat_any_q[s]   <= in_any_q;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ispm_pkg::*;

  typedef struct {
    action_e         action;
    logic [2:0]      slot;
    logic [4:0]      count;
    logic [127:0]    bytes;
    logic [15:0]     mask;
    logic            any_insn;
  } insn_word_t;

  typedef struct {
    logic            hit;
    logic [7:0]      total;
  } match_result_t;

  class match_scoreboard;
    logic [127:0]    win_bytes [PATTERN_DEPTH_DEF];
    logic [4:0]      win_size  [PATTERN_DEPTH_DEF];
    int              win_fill;
    logic [127:0]    pat_bytes [PATTERN_DEPTH_DEF];
    logic [15:0]     pat_mask  [PATTERN_DEPTH_DEF];
    logic [4:0]      pat_size  [PATTERN_DEPTH_DEF];
    bit              pat_any   [PATTERN_DEPTH_DEF];
    logic [3:0]      plen;
    match_result_t   expected [$];
    int              errors;

    function new();
      for (int i = 0; i < PATTERN_DEPTH_DEF; i++) begin
        win_bytes[i] = '0;
        win_size[i]  = '0;
        pat_bytes[i] = '0;
        pat_mask[i]  = '0;
        pat_size[i]  = '0;
        pat_any[i]   = 1'b0;
      end
      win_fill = 0;
      plen     = '0;
      errors   = 0;
    endfunction

    function bit slot_hit(int s, int e);
      if (pat_any[s]) return 1'b1;
      if (pat_size[s] != win_size[e]) return 1'b0;
      for (int i = 0; i < MAX_INSN_BYTES_DEF; i++) begin
        if (i < pat_size[s] && !pat_mask[s][i] &&
            pat_bytes[s][8*i +: 8] != win_bytes[e][8*i +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_word(insn_word_t w);
      match_result_t r;
      logic [4:0]    sz;
      int            depth;
      int            sum;
      bit            ok;
      r.hit   = 1'b0;
      r.total = '0;
      sz = (w.count > MAX_INSN_BYTES_DEF) ? 5'(MAX_INSN_BYTES_DEF) : w.count;
      if (w.action == ACT_PATTERN) begin
        pat_bytes[w.slot] = w.bytes;
        pat_mask[w.slot]  = w.mask;
        pat_size[w.slot]  = sz;
        pat_any[w.slot]   = w.any_insn;
      end else begin
        for (int k = PATTERN_DEPTH_DEF - 1; k > 0; k--) begin
          win_bytes[k] = win_bytes[k-1];
          win_size[k]  = win_size[k-1];
        end
        win_bytes[0] = w.bytes;
        win_size[0]  = sz;
        if (win_fill < PATTERN_DEPTH_DEF) win_fill++;
        depth = (plen > PATTERN_DEPTH_DEF) ? PATTERN_DEPTH_DEF : int'(plen);
        if (depth != 0 && win_fill >= depth) begin
          ok  = 1'b1;
          sum = 0;
          for (int k = 0; k < depth; k++) begin
            sum += win_size[k];
            if (!slot_hit(depth - 1 - k, k)) begin
              ok = 1'b0;
              break;
            end
          end
          if (ok) begin
            r.hit   = 1'b1;
            r.total = sum[7:0];
          end
        end
      end
      expected.push_back(r);
    endfunction

    function void check_result(logic hit, logic [7:0] total);
      match_result_t e;
      if (expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual matched=%0d bytes=%0d",
                 $time, hit, total);
        errors++;
        return;
      end
      e = expected.pop_front();
      if (hit !== e.hit) begin
        $display("%0t: matched mismatch, expected %0d, actual %0d", $time, e.hit, hit);
        errors++;
      end
      if (total !== e.total) begin
        $display("%0t: matched_bytes mismatch, expected %0d, actual %0d",
                 $time, e.total, total);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [PLEN_W-1:0]      cfg_data_i;

  match_scoreboard sb = new();
  bit steady;
  int holds_asked;

  localparam int PHASES = 11;
  localparam logic [3:0] LENGTHS [PHASES] = '{4'd1, 4'd8, 4'd15, 4'd3, 4'd0, 4'd5,
                                              4'd2, 4'd9, 4'd7, 4'd4, 4'd6};

  instruction_sequence_pattern_matcher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int holds_done;
    int hold_left;
    holds_done    = 0;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_asked != holds_done) begin
        holds_done++;
        hold_left = 90;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [127:0] rand_bytes();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  function automatic logic [4:0] rand_count();
    if ($urandom_range(0, 9) == 0) return 5'($urandom_range(17, 31));
    return 5'($urandom_range(0, 16));
  endfunction

  function automatic insn_word_t make_slot(int s);
    insn_word_t w;
    w.action   = ACT_PATTERN;
    w.slot     = 3'(s);
    w.count    = rand_count();
    w.bytes    = rand_bytes();
    w.any_insn = ($urandom_range(0, 4) == 0);
    case ($urandom_range(0, 3))
      0: w.mask = '0;
      1: w.mask = 16'($urandom() & $urandom() & $urandom());
      2: w.mask = 16'($urandom());
      default: w.mask = '1;
    endcase
    return w;
  endfunction

  function automatic insn_word_t noise_insn();
    insn_word_t w;
    w.action   = ACT_INSN;
    w.slot     = 3'($urandom());
    w.count    = rand_count();
    w.bytes    = rand_bytes();
    w.mask     = 16'($urandom());
    w.any_insn = 1'($urandom());
    return w;
  endfunction

  // instruction that the current pattern slot s accepts
  function automatic insn_word_t fit_insn(int s);
    insn_word_t w;
    w = noise_insn();
    if (!sb.pat_any[s]) begin
      w.count = sb.pat_size[s];
      if (sb.pat_size[s] == MAX_INSN_BYTES_DEF && $urandom_range(0, 1))
        w.count = 5'($urandom_range(16, 31));
      for (int i = 0; i < MAX_INSN_BYTES_DEF; i++) begin
        if (i < sb.pat_size[s] && !sb.pat_mask[s][i])
          w.bytes[8*i +: 8] = sb.pat_bytes[s][8*i +: 8];
      end
    end
    return w;
  endfunction

  function automatic insn_word_t spoil(insn_word_t w);
    int sz;
    sz = (w.count > MAX_INSN_BYTES_DEF) ? MAX_INSN_BYTES_DEF : int'(w.count);
    if (sz != 0 && $urandom_range(0, 1)) w.bytes[$urandom_range(0, 8*sz - 1)] ^= 1'b1;
    else w.count = 5'($urandom_range(0, 16));
    return w;
  endfunction

  // call at a falling edge; returns at the falling edge after the handshake
  task automatic push_word(input insn_word_t w);
    logic [IN_DATA_W-1:0] d;
    while (!steady && $urandom_range(0, 99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    d = '0;
    d[IN_SLOT_LSB  +: SLOT_W]  = w.slot;
    d[IN_COUNT_LSB +: COUNT_W] = w.count;
    d[IN_LOW_LSB   +: HALF_W]  = w.bytes[63:0];
    d[IN_HIGH_LSB  +: HALF_W]  = w.bytes[127:64];
    d[IN_MASK_LSB  +: MASK_W]  = w.mask;
    d[IN_ANY_LSB]              = w.any_insn;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= w.action;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(w);
    @(negedge clk_i);
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.expected.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_length(input logic [3:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.plen = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_sequences(input int budget);
    int         sent;
    int         depth;
    int         pick;
    int         bad;
    insn_word_t w;
    sent  = 0;
    depth = (sb.plen > PATTERN_DEPTH_DEF) ? PATTERN_DEPTH_DEF : int'(sb.plen);
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70 && depth > 0) begin
        bad = -1;
        if ($urandom_range(0, 4) == 0) bad = $urandom_range(0, depth - 1);
        for (int s = 0; s < depth; s++) begin
          w = fit_insn(s);
          if (s == bad) w = spoil(w);
          push_word(w);
          sent++;
        end
      end else if (pick < 80) begin
        push_word(make_slot($urandom_range(0, PATTERN_DEPTH_DEF - 1)));
        sent++;
      end else begin
        push_word(noise_insn());
        sent++;
      end
    end
  endtask

  initial begin
    insn_word_t w;
    steady        = 1'b0;
    holds_asked   = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // matching disabled, extreme words
    push_word('{ACT_INSN, 3'd7, 5'd31, '1, 16'hFFFF, 1'b1});
    push_word('{ACT_INSN, 3'd0, 5'd0, '0, 16'h0000, 1'b0});

    // any-instruction, empty, oversized and fully wildcarded slots
    push_word('{ACT_PATTERN, 3'd0, 5'd9, rand_bytes(), 16'h0000, 1'b1});
    push_word('{ACT_PATTERN, 3'd1, 5'd0, rand_bytes(), 16'h0000, 1'b0});
    push_word('{ACT_PATTERN, 3'd2, 5'd31, '1, 16'h0000, 1'b0});
    push_word('{ACT_PATTERN, 3'd3, 5'd5, rand_bytes(), 16'hFFFF, 1'b0});
    for (int s = 4; s < PATTERN_DEPTH_DEF; s++) push_word(make_slot(s));

    // short window first, then a full match
    wait_results_done();
    write_length(4'd4);
    for (int s = 0; s < 4; s++) push_word(fit_insn(s));

    // oversized length saturates to the full depth
    wait_results_done();
    write_length(4'd15);
    for (int s = 0; s < PATTERN_DEPTH_DEF; s++) push_word(fit_insn(s));

    for (int p = 0; p < PHASES; p++) begin
      wait_results_done();
      write_length(LENGTHS[p]);
      steady = (p == 1);
      if (p == 3) holds_asked++;
      if (p == 6) begin
        run_sequences(18);
        wait_results_done();
        run_sequences(18);
      end else begin
        run_sequences(36);
      end
      steady = 1'b0;
    end

    wait_results_done();
    repeat (6) @(negedge clk_i);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
